FILE: rtl/core/wps_pkg.sv
// Package for the word pattern search block: item types, codes and default sizes.
package wps_pkg;

    localparam int PAT_MAX_DEF          = 8;
    localparam int WORD_WIDTH_DEF       = 32;
    localparam int REGION_WORDS_MAX_DEF = 1048576;

    localparam int IN_WORD_W = 32;
    localparam int POS_W     = 20;
    localparam int CFG_LEN_W = 4;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_DATA = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_PATTERN_LEN  = 1'b0,
        CFG_SCAN_FORWARD = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                 cmd;
        logic [IN_WORD_W-1:0] word;
        logic                 last;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic load;
        logic fwd;
    } t_cell_ctrl;

endpackage

FILE: rtl/core/wps_cell.sv
// One window cell: a window word, a pattern word and their compare.
module wps_cell
    import wps_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [WORD_WIDTH-1:0] i_load_word,
    input  logic [WORD_WIDTH-1:0] i_win_in,
    input  logic [WORD_WIDTH-1:0] i_aligned_pat,
    output logic [WORD_WIDTH-1:0] o_win,
    output logic [WORD_WIDTH-1:0] o_pat,
    output logic                  o_eq
);

    logic [WORD_WIDTH-1:0] r_win;
    logic [WORD_WIDTH-1:0] r_pat;
    logic [WORD_WIDTH-1:0] n_win;
    logic [WORD_WIDTH-1:0] n_pat;

    always_comb begin
        n_win = i_ctrl.shift ? i_win_in : r_win;
        n_pat = i_ctrl.load ? i_load_word : r_pat;
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_pat <= n_pat;
    end

    // compare against the word that shifts in this cycle
    assign o_eq  = (i_win_in == (i_ctrl.fwd ? i_aligned_pat : r_pat));
    assign o_win = r_win;
    assign o_pat = r_pat;

endmodule

FILE: rtl/core/word_pattern_search_top.sv
// Word pattern search: finds the first match of a loaded pattern in a streamed region.
// Throughput is one transfer per clock cycle, pattern loads and region words alike: the
// window sits in a chain of PAT_MAX cells that all compare in the cycle a region word
// arrives, and the single result of a search (a match, or not found on the last word)
// appears on the output in the cycle after the transfer that causes it. A result waiting in
// the output register stalls the input only while the output side stalls it.
module word_pattern_search_top
    import wps_pkg::*;
#(
    parameter int PAT_MAX          = PAT_MAX_DEF,
    parameter int WORD_WIDTH       = WORD_WIDTH_DEF,
    parameter int REGION_WORDS_MAX = REGION_WORDS_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    localparam int CNT_W  = $clog2(PAT_MAX + 1);
    localparam int LW     = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;
    localparam int SEEN_W = $clog2(REGION_WORDS_MAX + 1);
    localparam int SH_W   = $clog2(PAT_MAX * WORD_WIDTH + 1);
    localparam int VEC_W  = PAT_MAX * WORD_WIDTH;

    logic [CFG_LEN_W-1:0] r_pat_len;
    logic                 r_scan_fwd;
    logic [CNT_W-1:0]     r_pat_cnt;
    logic [CNT_W-1:0]     n_pat_cnt;
    logic [SEEN_W-1:0]    r_seen;
    logic [SEEN_W-1:0]    n_seen;
    logic                 r_done;
    logic                 n_done;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;

    logic                  out_ready;
    logic                  in_fire;
    logic                  is_data;
    logic                  active;
    logic [WORD_WIDTH-1:0] word_in;
    logic [LW-1:0]         len_wide;
    logic [CNT_W-1:0]      len_eff;
    logic [CNT_W-1:0]      gap;
    logic [SH_W-1:0]       shamt;
    logic [VEC_W-1:0]      pat_rev;
    logic [VEC_W-1:0]      aligned_vec;
    logic [SEEN_W:0]       seen_p1;
    logic                  all_eq;
    logic                  hit;
    logic                  res_valid;
    t_out_item             res;

    t_cell_ctrl            cell_ctrl [PAT_MAX];
    logic [WORD_WIDTH-1:0] win_in    [PAT_MAX];
    logic [WORD_WIDTH-1:0] win_q     [PAT_MAX];
    logic [WORD_WIDTH-1:0] pat_q     [PAT_MAX];
    logic [WORD_WIDTH-1:0] aligned   [PAT_MAX];
    logic [PAT_MAX-1:0]    eq;
    logic [PAT_MAX-1:0]    used;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !out_ready;
    assign in_fire    = i_in_valid && out_ready;
    assign is_data    = (t_cmd'(i_in_data.cmd) == CMD_DATA);
    assign word_in    = i_in_data.word[WORD_WIDTH-1:0];

    assign len_wide = LW'(r_pat_len);
    assign len_eff  = (len_wide > LW'(PAT_MAX)) ? CNT_W'(PAT_MAX) : CNT_W'(len_wide);
    assign gap      = CNT_W'(PAT_MAX) - len_eff;
    assign shamt    = SH_W'(gap) * SH_W'(WORD_WIDTH);

    // forward scan: cell k pairs with pattern word len-1-k
    assign aligned_vec = pat_rev >> shamt;

    genvar k;
    generate
        for (k = 0; k < PAT_MAX; k++) begin : g_cell
            assign pat_rev[k*WORD_WIDTH +: WORD_WIDTH] = pat_q[PAT_MAX-1-k];
            assign aligned[k] = aligned_vec[k*WORD_WIDTH +: WORD_WIDTH];
            assign used[k]    = (CNT_W'(k) < len_eff);
            if (k == 0) begin : g_head
                assign win_in[k] = word_in;
            end else begin : g_body
                assign win_in[k] = win_q[k-1];
            end
            assign cell_ctrl[k].shift = in_fire && is_data && active;
            assign cell_ctrl[k].load  = in_fire && !is_data && (r_pat_cnt == CNT_W'(k));
            assign cell_ctrl[k].fwd   = r_scan_fwd;

            wps_cell #(
                .WORD_WIDTH (WORD_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (cell_ctrl[k]),
                .i_load_word   (word_in),
                .i_win_in      (win_in[k]),
                .i_aligned_pat (aligned[k]),
                .o_win         (win_q[k]),
                .o_pat         (pat_q[k]),
                .o_eq          (eq[k])
            );
        end
    endgenerate

    assign active  = !r_done && (r_seen < SEEN_W'(REGION_WORDS_MAX));
    assign seen_p1 = {1'b0, r_seen} + (SEEN_W+1)'(1);
    assign all_eq  = &(eq | ~used);
    assign hit     = is_data && active
                   && ((len_eff == '0) || ((seen_p1 >= (SEEN_W+1)'(len_eff)) && all_eq));

    always_comb begin
        res_valid    = 1'b0;
        res.found    = 1'b0;
        res.position = '0;
        if (hit) begin
            res_valid = 1'b1;
            res.found = 1'b1;
            if (len_eff == '0) begin
                res.position = '0;
            end else if (r_scan_fwd) begin
                res.position = POS_W'(seen_p1 - (SEEN_W+1)'(len_eff));
            end else begin
                res.position = POS_W'(r_seen);
            end
        end else if (is_data && i_in_data.last && !r_done) begin
            res_valid = 1'b1;
        end
    end

    always_comb begin
        n_pat_cnt = r_pat_cnt;
        n_seen    = r_seen;
        n_done    = r_done;
        if (in_fire) begin
            if (!is_data) begin
                if (r_pat_cnt < CNT_W'(PAT_MAX)) begin
                    n_pat_cnt = r_pat_cnt + CNT_W'(1);
                end
            end else if (i_in_data.last) begin
                n_pat_cnt = '0;
                n_seen    = '0;
                n_done    = 1'b0;
            end else begin
                if (hit) begin
                    n_done = 1'b1;
                end
                if (active) begin
                    n_seen = r_seen + SEEN_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_ready) begin
            n_out_valid = in_fire && res_valid;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len   <= CFG_LEN_W'(1);
            r_scan_fwd  <= 1'b1;
            r_pat_cnt   <= '0;
            r_seen      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pat_cnt   <= n_pat_cnt;
            r_seen      <= n_seen;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PATTERN_LEN: begin
                        r_pat_len <= i_cfg_data[CFG_LEN_W-1:0];
                    end
                    CFG_SCAN_FORWARD: begin
                        r_scan_fwd <= i_cfg_data[0];
                    end
                    default: begin
                        r_scan_fwd <= r_scan_fwd;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat_cnt <= CNT_W'(PAT_MAX))
        else $error("pattern count beyond capacity");

    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(REGION_WORDS_MAX))
        else $error("word count beyond region limit");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && is_data && i_in_data.last
        |=> (r_seen == '0) && !r_done && (r_pat_cnt == '0))
        else $error("search state not cleared after last word");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && res_valid |-> !r_done)
        else $error("second result in one search");

    a_done_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && hit && !i_in_data.last |=> r_done)
        else $error("match not recorded");

    a_notfound_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && res_valid && !res.found |=> o_out_valid && (o_out_data.position == '0))
        else $error("not-found result with nonzero position");

endmodule
